### src/kls_pkg.sv
// Package of shared types, constants and the keyword lookup for the keyword lexer.
package kls_pkg;

  localparam int unsigned SourceBytes = 1048576;
  localparam int unsigned PosW = $clog2(SourceBytes + 1);
  localparam logic [20:0] LenCap = 21'd1048576;
  localparam logic [19:0] StartCap = 20'hFFFFF;

  localparam logic [5:0] KindIdent = 6'd0;
  localparam logic [5:0] KindNumber = 6'd1;
  localparam logic [5:0] KindString = 6'd2;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_STRING, MODE_NUMBER, MODE_WORD
  } mode_t;

  typedef enum logic [2:0] {
    PH_UNDECIDED, PH_ZERO, PH_ZEROX, PH_OCT, PH_DEC, PH_HEX
  } phase_t;

  // One pending token, classified by the front end; the back end resolves it.
  typedef struct packed {
    logic [1:0]  kind_sel;  // 0 word, 1 number, 2 string
    logic [19:0] start;
    logic [20:0] length;
    logic [63:0] chars;
    logic [63:0] mag;
    logic        neg;
    logic        ovf;
    logic        last;
  } tok_t;

  localparam logic [1:0] SelWord = 2'd0;
  localparam logic [1:0] SelNumber = 2'd1;
  localparam logic [1:0] SelString = 2'd2;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [20:0] length;
    logic [63:0] value;
    logic        last;
  } res_t;

  function automatic logic [63:0] pack_str(input string s);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < s.len()) p[8*i +: 8] = s[i];
    end
    return p;
  endfunction

  function automatic logic [5:0] keyword_kind(input logic [63:0] w, input logic [20:0] n);
    logic [5:0] k;
    k = KindIdent;
    if (n != 21'd0 && n <= 21'd8) begin
      case (w)
        pack_str("a"): k = 6'd3;        pack_str("an"): k = 6'd4;
        pack_str("if"): k = 6'd5;       pack_str("it"): k = 6'd6;
        pack_str("end"): k = 6'd7;      pack_str("add"): k = 6'd8;
        pack_str("pop"): k = 6'd9;      pack_str("call"): k = 6'd10;
        pack_str("from"): k = 6'd11;    pack_str("into"): k = 6'd12;
        pack_str("less"): k = 6'd13;    pack_str("load"): k = 6'd14;
        pack_str("move"): k = 6'd15;    pack_str("push"): k = 6'd16;
        pack_str("with"): k = 6'd17;    pack_str("byte"): k = 6'd18;
        pack_str("char"): k = 6'd19;    pack_str("halt"): k = 6'd20;
        pack_str("exit"): k = 6'd20;    pack_str("equal"): k = 6'd21;
        pack_str("print"): k = 6'd22;   pack_str("store"): k = 6'd23;
        pack_str("short"): k = 6'd24;   pack_str("shift"): k = 6'd25;
        pack_str("define"): k = 6'd26;  pack_str("return"): k = 6'd27;
        pack_str("while"): k = 6'd28;   pack_str("bitor"): k = 6'd29;
        pack_str("long"): k = 6'd30;    pack_str("compare"): k = 6'd31;
        pack_str("greater"): k = 6'd32; pack_str("syscall"): k = 6'd33;
        pack_str("integer"): k = 6'd34; pack_str("bitand"): k = 6'd35;
        pack_str("bitxor"): k = 6'd36;  pack_str("subtract"): k = 6'd37;
        pack_str("multiply"): k = 6'd38; pack_str("divide"): k = 6'd39;
        pack_str("boolean"): k = 6'd40; pack_str("global"): k = 6'd41;
        pack_str("bitnot"): k = 6'd42;
        default: k = KindIdent;
      endcase
      // Packed spelling length equals the nonzero byte count, so check it.
      if (k != KindIdent) begin
        for (int i = 0; i < 8; i++) begin
          if ((w[8*i +: 8] != 8'd0) != (21'(i) < n)) k = KindIdent;
        end
      end
    end
    return k;
  endfunction

endpackage

### src/kls_front.sv
// Front end of the lexer: scans bytes and produces pending tokens.
module kls_front import kls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] src_byte,
  input  logic       final_byte,
  output logic       in_ready,
  output logic       tok_valid0,
  output tok_t       tok0,
  output logic       tok_valid1,
  output tok_t       tok1,
  input  logic       room2
);

  mode_t mode, mode_next;
  logic minus_pending, minus_pending_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [19:0] start_offset, start_offset_next;
  logic [20:0] run_length, run_length_next;
  logic [63:0] word_chars, word_chars_next;
  logic [63:0] magnitude, magnitude_next;
  phase_t phase, phase_next;
  logic fneg, fstop, fovf, fneg_next, fstop_next, fovf_next;

  assign in_ready = room2;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic [4:0] dval(input logic [7:0] c);
    if (is_dig(c)) return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd31;
  endfunction

  tok_t cur;
  always_comb begin
    cur.kind_sel = (mode == MODE_NUMBER) ? SelNumber :
                   (mode == MODE_STRING) ? SelString : SelWord;
    cur.start = start_offset;
    cur.length = run_length;
    cur.chars = word_chars;
    cur.mag = magnitude;
    cur.neg = fneg;
    cur.ovf = fovf;
    cur.last = 1'b0;
  end

  logic [19:0] pos20;
  logic [63:0] acc_cap;
  logic [4:0] dd;
  logic [4:0] rdx;
  logic acc_do;

  always_comb begin
    logic [7:0] c;
    logic pend, fl_mode, idle_go;
    c = src_byte;
    pos20 = (byte_position > PosW'(StartCap)) ? StartCap : byte_position[19:0];
    mode_next = mode; minus_pending_next = minus_pending;
    start_offset_next = start_offset; run_length_next = run_length;
    word_chars_next = word_chars; magnitude_next = magnitude; phase_next = phase;
    fneg_next = fneg; fstop_next = fstop; fovf_next = fovf;
    tok_valid0 = 1'b0; tok0 = cur; tok_valid1 = 1'b0; tok1 = cur;
    idle_go = 1'b0; pend = 1'b0; fl_mode = 1'b0;
    acc_do = 1'b0; rdx = 5'd10; dd = dval(c);
    acc_cap = '0;
    byte_position_next = (byte_position < PosW'(SourceBytes)) ?
                         byte_position + 1'b1 : byte_position;
    case (mode)
      MODE_COMMENT: if (c == 8'h0A) mode_next = MODE_IDLE;
      MODE_STRING: begin
        if (c == "\"") begin
          tok_valid0 = 1'b1; mode_next = MODE_IDLE;
        end else if (run_length < LenCap) begin
          run_length_next = run_length + 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_dig(c) || is_alp(c)) begin
          if (run_length < LenCap) run_length_next = run_length + 1'b1;
          pend = 1'b1;
        end else begin
          tok_valid0 = 1'b1; idle_go = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_dig(c) || is_alp(c) || c == "_") begin
          if (run_length < 21'd8) word_chars_next[8*run_length[2:0] +: 8] = c;
          if (run_length < LenCap) run_length_next = run_length + 1'b1;
        end else begin
          tok_valid0 = 1'b1; idle_go = 1'b1;
        end
      end
      default: idle_go = 1'b1;
    endcase
    if (idle_go) begin
      mode_next = MODE_IDLE;
      if (minus_pending && is_dig(c)) begin
        minus_pending_next = 1'b0;
        mode_next = MODE_NUMBER; run_length_next = 21'd2;
        magnitude_next = '0; phase_next = PH_UNDECIDED;
        fneg_next = 1'b1; fstop_next = 1'b0; fovf_next = 1'b0; pend = 1'b1;
      end else begin
        minus_pending_next = 1'b0;
        if (c == "#") mode_next = MODE_COMMENT;
        else if (c == "\"") begin
          // The string body starts one past the quote; the offset saturates.
          mode_next = MODE_STRING; run_length_next = '0;
          start_offset_next = (pos20 == StartCap) ? StartCap : pos20 + 1'b1;
        end else if (is_dig(c)) begin
          mode_next = MODE_NUMBER; start_offset_next = pos20; run_length_next = 21'd1;
          magnitude_next = '0; phase_next = PH_UNDECIDED;
          fneg_next = 1'b0; fstop_next = 1'b0; fovf_next = 1'b0; pend = 1'b1;
        end else if (c == "-") begin
          minus_pending_next = 1'b1; start_offset_next = pos20;
        end else if (is_alp(c) || c == "_") begin
          mode_next = MODE_WORD; start_offset_next = pos20; run_length_next = 21'd1;
          word_chars_next = {56'd0, c};
        end
      end
    end
    // Digit feed: uses the running phase and flags, or a new token's.
    if (pend) begin
      phase_t ph;
      logic st;
      ph = (mode == MODE_NUMBER && !idle_go) ? phase : PH_UNDECIDED;
      st = (mode == MODE_NUMBER && !idle_go) ? fstop : 1'b0;
      if (!st) begin
        case (ph)
          PH_UNDECIDED: begin
            if (c == "0") phase_next = PH_ZERO;
            else if (dd < 5'd10) begin phase_next = PH_DEC; acc_do = 1'b1; rdx = 5'd10; end
            else fstop_next = 1'b1;
          end
          PH_ZERO: begin
            if (c == "x" || c == "X") phase_next = PH_ZEROX;
            else if (dd < 5'd8) begin phase_next = PH_OCT; acc_do = 1'b1; rdx = 5'd8; end
            else fstop_next = 1'b1;
          end
          PH_ZEROX: begin
            if (dd < 5'd16) begin phase_next = PH_HEX; acc_do = 1'b1; rdx = 5'd16; end
            else begin magnitude_next = '0; fstop_next = 1'b1; end
          end
          PH_OCT: if (dd < 5'd8) begin acc_do = 1'b1; rdx = 5'd8; end else fstop_next = 1'b1;
          PH_DEC: if (dd < 5'd10) begin acc_do = 1'b1; rdx = 5'd10; end else fstop_next = 1'b1;
          default: if (dd < 5'd16) begin acc_do = 1'b1; rdx = 5'd16; end
                   else fstop_next = 1'b1;
        endcase
      end
      if (acc_do && !fovf_next) begin
        logic [63:0] m;
        m = (mode == MODE_NUMBER && !idle_go) ? magnitude : 64'd0;
        acc_cap = fneg_next ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        // m*rdx + d > cap  <=>  overflow; compare in 69 bits (constant radix shifts).
        begin
          logic [68:0] full;
          case (rdx)
            5'd8:  full = {5'd0, m} << 3;
            5'd16: full = {5'd0, m} << 4;
            default: full = ({5'd0, m} << 3) + ({5'd0, m} << 1);
          endcase
          full = full + 69'(dd);
          if (full > {5'd0, acc_cap}) fovf_next = 1'b1;
          else magnitude_next = full[63:0];
        end
      end
    end
    fl_mode = (mode_next == MODE_NUMBER) || (mode_next == MODE_WORD) ||
              (mode_next == MODE_STRING);
    if (final_byte) begin
      tok_t t;
      t.kind_sel = (mode_next == MODE_NUMBER) ? SelNumber :
                   (mode_next == MODE_STRING) ? SelString : SelWord;
      t.start = start_offset_next; t.length = run_length_next;
      t.chars = word_chars_next; t.mag = magnitude_next;
      t.neg = fneg_next; t.ovf = fovf_next; t.last = 1'b1;
      if (fl_mode) begin
        if (tok_valid0) begin tok_valid1 = 1'b1; tok1 = t; end
        else begin tok_valid0 = 1'b1; tok0 = t; end
      end else begin
        tok0.last = 1'b1;
      end
      mode_next = MODE_IDLE; minus_pending_next = 1'b0; byte_position_next = '0;
      start_offset_next = '0; run_length_next = '0; word_chars_next = '0;
      magnitude_next = '0; phase_next = PH_UNDECIDED;
      fneg_next = 1'b0; fstop_next = 1'b0; fovf_next = 1'b0;
    end else if (!tok_valid1) begin
      tok0.last = 1'b1;
    end
    if (!(in_valid && room2)) begin
      tok_valid0 = 1'b0; tok_valid1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; minus_pending <= 1'b0; byte_position <= '0;
      start_offset <= '0; run_length <= '0; word_chars <= '0; magnitude <= '0;
      phase <= PH_UNDECIDED; fneg <= 1'b0; fstop <= 1'b0; fovf <= 1'b0;
    end else if (in_valid && room2) begin
      mode <= mode_next; minus_pending <= minus_pending_next;
      byte_position <= byte_position_next; start_offset <= start_offset_next;
      run_length <= run_length_next; word_chars <= word_chars_next;
      magnitude <= magnitude_next; phase <= phase_next;
      fneg <= fneg_next; fstop <= fstop_next; fovf <= fovf_next;
    end
  end

endmodule

### src/kls_queue.sv
// Short token queue between front end and back end; takes up to two per cycle.
module kls_queue import kls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr0,
  input  tok_t d0,
  input  logic wr1,
  input  tok_t d1,
  output logic room2,
  output logic rd_valid,
  output tok_t rd_data,
  input  logic rd
);

  localparam int Depth = 4;
  tok_t mem [Depth];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic do_rd;

  assign room2 = cnt <= 3'(Depth - 2);
  assign rd_valid = cnt != 3'd0;
  assign rd_data = mem[rp];
  assign do_rd = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (wr0) mem[wp] <= d0;
    if (wr1) mem[wp + 2'd1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + 2'(wr0) + 2'(wr1);
      rp <= rp + 2'(do_rd);
      cnt <= cnt + 3'(wr0) + 3'(wr1) - 3'(do_rd);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'(Depth))
    else $error("token queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) wr1 |-> wr0)
    else $error("second token written without first");
  assert property (@(posedge clk) disable iff (rst) (wr0 || wr1) |-> $past(room2) || room2)
    else $error("token written without room");

endmodule

### src/kls_back.sv
// Back end: resolves keyword kind and signed value, holds the result register.
module kls_back import kls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  tok_t tok,
  output logic in_take,
  output logic out_valid,
  output res_t res,
  input  logic out_pop
);

  res_t r;
  always_comb begin
    r.kind = (tok.kind_sel == SelNumber) ? KindNumber :
             (tok.kind_sel == SelString) ? KindString : keyword_kind(tok.chars, tok.length);
    r.start = tok.start;
    r.length = tok.length;
    if (tok.kind_sel != SelNumber) r.value = '0;
    else if (tok.ovf) r.value = tok.neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    else r.value = tok.neg ? 64'd0 - tok.mag : tok.mag;
    r.last = tok.last;
  end

  assign in_take = in_valid && (!out_valid || out_pop);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_take) out_valid <= 1'b1;
    else if (out_pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take) res <= r;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pop) |=> out_valid && $stable(res))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.kind != KindNumber |-> res.value == 64'd0)
    else $error("nonzero value on non-number");
  assert property (@(posedge clk) disable iff (rst) in_take |-> in_valid)
    else $error("take without token");

endmodule

### src/keyword_lexer_stream.sv
// Top level of the streaming keyword lexer.
// One source byte is taken per cycle while full is low, back to back; each byte's
// scan, radix accumulate and token cut happen in that cycle in the front end.
// Finished tokens pass a four-entry queue to the back end, which looks up the
// keyword kind and forms the signed value into a result register; a byte may
// cause up to two tokens, so full rises when fewer than two entries are free.
// Results drain one per cycle on pop, so the sustained rate is one byte per cycle
// whenever results are taken as fast as they are made. run_end marks the last
// token caused by one byte. A final byte flushes any pending token and restarts
// offsets at zero. No clearing pass follows reset.
module keyword_lexer_stream import kls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  src_byte,
  input  logic        final_byte,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind,
  output logic [19:0] token_start,
  output logic [20:0] token_length,
  output logic signed [63:0] number_value,
  output logic        run_end
);

  logic in_ready, room2, tv0, tv1, q_valid, q_take, out_valid;
  tok_t t0, t1, q_tok;
  res_t res;

  kls_front u_front (
    .clk, .rst, .in_valid(push), .src_byte, .final_byte, .in_ready,
    .tok_valid0(tv0), .tok0(t0), .tok_valid1(tv1), .tok1(t1), .room2
  );

  kls_queue u_queue (
    .clk, .rst, .wr0(tv0), .d0(t0), .wr1(tv1), .d1(t1), .room2,
    .rd_valid(q_valid), .rd_data(q_tok), .rd(q_take)
  );

  kls_back u_back (
    .clk, .rst, .in_valid(q_valid), .tok(q_tok), .in_take(q_take),
    .out_valid, .res, .out_pop(pop)
  );

  // The input side stalls only on lack of queue room for a two-token transfer.
  assign full = !in_ready;
  assign empty = !out_valid;
  assign token_kind = res.kind;
  assign token_start = res.start;
  assign token_length = res.length;
  assign number_value = res.value;
  assign run_end = res.last;

endmodule
